// File: rtl/aesm_pkg.sv
package aesm_pkg;

  localparam int P_MAX       = 30;   // widest coding interval
  localparam int P_MIN       = 9;
  localparam int P_W         = 5;
  localparam int VAL_W       = 30;
  localparam int SYM_W       = 8;
  localparam int PEND_W      = 16;
  localparam int LEN_W       = 17;
  localparam int PROD_W      = 2 * VAL_W;
  localparam int TBL_DEPTH   = 256;
  localparam int RES_DEPTH   = 64;
  localparam int RES_AW      = $clog2(RES_DEPTH);
  localparam int CNT_W       = RES_AW + 1;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [P_W-1:0]    P_RESET    = P_W'(16);
  localparam logic [PEND_W-1:0] PEND_LIMIT = '1;
  localparam logic [SYM_W-1:0]  SYM_LAST   = '1;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_ENCODE = 2'd1,
    CMD_FLUSH  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_ENCODE = 2'd1,
    KIND_FLUSH  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [SYM_W-1:0]  symbol;
    logic [VAL_W-1:0]  value;
  } req_t;

  function automatic logic [P_W-1:0] clamp_p(input logic [P_W-1:0] p);
    logic [P_W-1:0] r;
    r = p;
    if (p < P_W'(P_MIN)) r = P_W'(P_MIN);
    if (p > P_W'(P_MAX)) r = P_W'(P_MAX);
    return r;
  endfunction

  function automatic logic [VAL_W-1:0] mask_of(input logic [P_W-1:0] p);
    logic [VAL_W-1:0] ones;
    ones = '1;
    return ~(ones << p);
  endfunction

endpackage

// File: rtl/aesm_front.sv
module aesm_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 command,
  input  logic [aesm_pkg::SYM_W-1:0] symbol,
  input  logic [aesm_pkg::VAL_W-1:0] table_value,
  output logic                       q_valid,
  input  logic                       q_ready,
  output aesm_pkg::req_t             q_req
);

  aesm_pkg::req_t q_mem [aesm_pkg::QUEUE_DEPTH];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     cnt;
  logic           keep;
  aesm_pkg::req_t cls;
  logic           push;
  logic           pop;

  // classify: drop unknown commands and loads of the fixed entry zero
  always_comb begin
    keep       = 1'b0;
    cls.symbol = symbol;
    cls.value  = table_value;
    cls.kind   = aesm_pkg::KIND_ENCODE;
    unique case (aesm_pkg::cmd_t'(command))
      aesm_pkg::CMD_LOAD: begin
        cls.kind = aesm_pkg::KIND_LOAD;
        keep     = (symbol != '0);
      end
      aesm_pkg::CMD_ENCODE: begin
        cls.kind = aesm_pkg::KIND_ENCODE;
        keep     = 1'b1;
      end
      aesm_pkg::CMD_FLUSH: begin
        cls.kind = aesm_pkg::KIND_FLUSH;
        keep     = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_ready = (cnt != 2'(aesm_pkg::QUEUE_DEPTH));
  assign q_valid  = (cnt != '0);
  assign q_req    = q_mem[rd_ptr];
  assign push     = in_valid && in_ready && keep;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) q_mem[wr_ptr] <= cls;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

endmodule

// File: rtl/aesm_back.sv
module aesm_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write_en,
  input  logic [aesm_pkg::P_W-1:0]   cfg_write_data,
  input  logic                       q_valid,
  output logic                       q_ready,
  input  aesm_pkg::req_t             q_req,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       code_bit,
  output logic [aesm_pkg::LEN_W-1:0] run_length,
  output logic                       last,
  output logic                       error
);

  typedef enum logic [12:0] {
    ST_IDLE       = 13'b0000000000001,
    ST_LOOK_LO    = 13'b0000000000010,
    ST_LOOK_HI    = 13'b0000000000100,
    ST_MUL_LO     = 13'b0000000001000,
    ST_MUL_HI     = 13'b0000000010000,
    ST_CHECK      = 13'b0000000100000,
    ST_FLUSH_ADD  = 13'b0000001000000,
    ST_RENORM     = 13'b0000010000000,
    ST_RELEASE    = 13'b0000100000000,
    ST_FINISH     = 13'b0001000000000,
    ST_DRAIN_RD   = 13'b0010000000000,
    ST_DRAIN_LOAD = 13'b0100000000000,
    ST_DRAIN_WAIT = 13'b1000000000000
  } state_t;

  typedef struct packed {
    logic                       bit_v;
    logic [aesm_pkg::LEN_W-1:0] len;
  } run_t;

  localparam int VW = aesm_pkg::VAL_W;
  localparam int PW = aesm_pkg::P_W;

  // table and result buffer
  logic [VW-1:0] store [aesm_pkg::TBL_DEPTH];
  run_t          res_mem [aesm_pkg::RES_DEPTH];
  logic [VW-1:0] tbl_rdata;
  run_t          res_rdata;
  logic [aesm_pkg::SYM_W-1:0] tbl_raddr;

  state_t state, state_next;
  logic [PW-1:0] prec;
  logic [PW-1:0] p;
  logic [VW-1:0] mask;

  logic [VW-1:0] low, low_next;
  logic [VW-1:0] range, range_next;
  logic          hv, hv_next;
  logic          hb, hb_next;
  logic [aesm_pkg::PEND_W-1:0] pend, pend_next;
  logic          err, err_next;
  logic          is_flush, is_flush_next;
  logic [aesm_pkg::CNT_W-1:0] count, count_next;
  logic [aesm_pkg::CNT_W-1:0] idx, idx_next;
  logic          spill_v, spill_v_next;
  run_t          spill, spill_next;
  logic [aesm_pkg::SYM_W-1:0] sym, sym_next;
  logic [VW-1:0] lo_op, lo_op_next;
  logic [VW-1:0] hi_op, hi_op_next;
  logic [VW-1:0] inc, inc_next;
  logic [aesm_pkg::PROD_W-1:0] prod, prod_next;
  logic          out_valid_next;
  run_t          out_run, out_run_next;
  logic          last_next, error_next;

  logic          res_we;
  logic [aesm_pkg::RES_AW-1:0] res_waddr;
  run_t          res_wdata;
  logic          tbl_we;

  // helpers
  run_t          ra, rb;
  logic          ra_v, rb_v;
  logic [VW-1:0] sat_rd;
  logic [aesm_pkg::PROD_W-1:0] prod_sh;
  logic [VW-1:0] y_val;
  logic [VW:0]   sum_w;
  logic [VW:0]   sum_sh;
  logic [VW-1:0] addend;
  logic          carry;
  logic [VW-1:0] top_sh;
  logic          top_bit;
  logic [VW-1:0] half_sh;
  logic [VW-1:0] quarter;
  logic          renorm_go;
  logic          room;

  assign p       = aesm_pkg::clamp_p(prec);
  assign mask    = aesm_pkg::mask_of(p);
  assign q_ready = (state == ST_IDLE);
  assign sat_rd  = (tbl_rdata > mask) ? mask : tbl_rdata;
  assign prod_sh = prod >> p;
  assign y_val   = prod_sh[VW-1:0];
  assign quarter = VW'(1) << (p - PW'(2));
  assign addend  = (state == ST_FLUSH_ADD) ? quarter : inc;
  assign sum_w   = {1'b0, low} + {1'b0, addend};
  assign sum_sh  = sum_w >> p;
  assign carry   = sum_sh[0];
  assign top_sh  = low >> (p - PW'(1));
  assign top_bit = top_sh[0];
  assign half_sh = range >> (p - PW'(1));
  assign renorm_go = (range != '0) && (half_sh == '0);
  assign room    = (count < aesm_pkg::CNT_W'(aesm_pkg::RES_DEPTH));

  always_comb begin
    tbl_raddr = sym - aesm_pkg::SYM_W'(1);
    if (state == ST_LOOK_HI) tbl_raddr = sym;
  end

  always_comb begin
    state_next     = state;
    low_next       = low;
    range_next     = range;
    hv_next        = hv;
    hb_next        = hb;
    pend_next      = pend;
    err_next       = err;
    is_flush_next  = is_flush;
    count_next     = count;
    idx_next       = idx;
    spill_v_next   = spill_v;
    spill_next     = spill;
    sym_next       = sym;
    lo_op_next     = lo_op;
    hi_op_next     = hi_op;
    inc_next       = inc;
    prod_next      = prod;
    out_valid_next = out_valid;
    out_run_next   = out_run;
    last_next      = last;
    error_next     = error;
    tbl_we         = 1'b0;
    res_we         = 1'b0;
    res_waddr      = count[aesm_pkg::RES_AW-1:0];
    res_wdata      = spill;
    ra_v           = 1'b0;
    rb_v           = 1'b0;
    ra             = '0;
    rb             = '0;

    if (spill_v) begin
      // drain the second run of a pair before doing anything else
      res_we       = room;
      res_wdata    = spill;
      count_next   = count + aesm_pkg::CNT_W'(room);
      spill_v_next = 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            sym_next      = q_req.symbol;
            err_next      = 1'b0;
            count_next    = '0;
            is_flush_next = 1'b0;
            unique case (q_req.kind)
              aesm_pkg::KIND_LOAD:   tbl_we = 1'b1;
              aesm_pkg::KIND_ENCODE: state_next = ST_LOOK_LO;
              aesm_pkg::KIND_FLUSH: begin
                is_flush_next = 1'b1;
                state_next    = ST_FLUSH_ADD;
              end
              default: state_next = ST_IDLE;
            endcase
          end
        end
        ST_LOOK_LO: state_next = ST_LOOK_HI;
        ST_LOOK_HI: begin
          lo_op_next = (sym == '0) ? '0 : sat_rd;
          state_next = ST_MUL_LO;
        end
        ST_MUL_LO: begin
          hi_op_next = (sym == aesm_pkg::SYM_LAST) ? mask : sat_rd;
          prod_next  = aesm_pkg::PROD_W'(range) * aesm_pkg::PROD_W'(lo_op);
          state_next = ST_MUL_HI;
        end
        ST_MUL_HI: begin
          inc_next   = prod_sh[VW-1:0];
          prod_next  = aesm_pkg::PROD_W'(range) * aesm_pkg::PROD_W'(hi_op);
          state_next = ST_CHECK;
        end
        ST_CHECK, ST_FLUSH_ADD: begin
          if ((state == ST_CHECK) && (y_val <= inc)) begin
            // reject: empty interval, state stays as it was
            err_next   = 1'b1;
            state_next = ST_FINISH;
          end else begin
            low_next   = sum_w[VW-1:0] & mask;
            range_next = (state == ST_CHECK) ? (y_val - inc) : (quarter - VW'(1));
            state_next = ST_RENORM;
            if (carry && hv && !hb) begin
              if (pend == '0) begin
                hb_next = 1'b1;
              end else begin
                ra_v      = 1'b1;
                ra        = '{bit_v: 1'b1, len: aesm_pkg::LEN_W'(1)};
                rb_v      = (pend != aesm_pkg::PEND_W'(1));
                rb        = '{bit_v: 1'b0,
                              len: {1'b0, pend} - aesm_pkg::LEN_W'(1)};
                hb_next   = 1'b0;
                pend_next = '0;
              end
            end
          end
        end
        ST_RENORM: begin
          if (renorm_go) begin
            low_next   = (low << 1) & mask;
            range_next = (range << 1) & mask;
            if (!hv) begin
              hv_next   = 1'b1;
              hb_next   = top_bit;
              pend_next = '0;
            end else if (top_bit) begin
              if (pend == aesm_pkg::PEND_LIMIT) err_next = 1'b1;
              else pend_next = pend + aesm_pkg::PEND_W'(1);
            end else begin
              ra_v = 1'b1;
              if (hb) begin
                ra = '{bit_v: 1'b1, len: {1'b0, pend} + aesm_pkg::LEN_W'(1)};
              end else begin
                ra   = '{bit_v: 1'b0, len: aesm_pkg::LEN_W'(1)};
                rb_v = (pend != '0);
                rb   = '{bit_v: 1'b1, len: {1'b0, pend}};
              end
              hv_next   = 1'b1;
              hb_next   = 1'b0;
              pend_next = '0;
            end
          end else begin
            state_next = is_flush ? ST_RELEASE : ST_FINISH;
          end
        end
        ST_RELEASE: begin
          // release everything held, then restart the interval
          if (hv) begin
            ra_v = 1'b1;
            if (hb) begin
              ra = '{bit_v: 1'b1, len: {1'b0, pend} + aesm_pkg::LEN_W'(1)};
            end else begin
              ra   = '{bit_v: 1'b0, len: aesm_pkg::LEN_W'(1)};
              rb_v = (pend != '0);
              rb   = '{bit_v: 1'b1, len: {1'b0, pend}};
            end
          end
          low_next   = '0;
          range_next = mask;
          hv_next    = 1'b0;
          hb_next    = 1'b0;
          pend_next  = '0;
          state_next = ST_FINISH;
        end
        ST_FINISH: begin
          idx_next = '0;
          if (err && (count == '0)) begin
            res_we     = 1'b1;
            res_wdata  = '{bit_v: 1'b0, len: '0};
            count_next = aesm_pkg::CNT_W'(1);
            state_next = ST_DRAIN_RD;
          end else begin
            state_next = (count == '0) ? ST_IDLE : ST_DRAIN_RD;
          end
        end
        ST_DRAIN_RD: state_next = ST_DRAIN_LOAD;
        ST_DRAIN_LOAD: begin
          out_valid_next = 1'b1;
          out_run_next   = res_rdata;
          error_next     = err;
          last_next      = is_flush && ((idx + aesm_pkg::CNT_W'(1)) == count);
          state_next     = ST_DRAIN_WAIT;
        end
        ST_DRAIN_WAIT: begin
          if (out_ready) begin
            out_valid_next = 1'b0;
            idx_next       = idx + aesm_pkg::CNT_W'(1);
            state_next     = ((idx + aesm_pkg::CNT_W'(1)) == count) ? ST_IDLE
                                                                      : ST_DRAIN_RD;
          end
        end
        default: state_next = ST_IDLE;
      endcase

      // write up to one run now, park a second one
      if (ra_v) begin
        res_we       = room;
        res_wdata    = ra;
        count_next   = count + aesm_pkg::CNT_W'(room);
        spill_v_next = rb_v;
        spill_next   = rb;
      end else if (rb_v) begin
        res_we     = room;
        res_wdata  = rb;
        count_next = count + aesm_pkg::CNT_W'(room);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) store[q_req.symbol - aesm_pkg::SYM_W'(1)] <= q_req.value;
    tbl_rdata <= store[tbl_raddr];
    if (res_we) res_mem[res_waddr] <= res_wdata;
    res_rdata <= res_mem[idx[aesm_pkg::RES_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    sym      <= sym_next;
    lo_op    <= lo_op_next;
    hi_op    <= hi_op_next;
    inc      <= inc_next;
    prod     <= prod_next;
    spill    <= spill_next;
    out_run  <= out_run_next;
    last     <= last_next;
    error    <= error_next;
    idx      <= idx_next;
    err      <= err_next;
    is_flush <= is_flush_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      prec      <= aesm_pkg::P_RESET;
      low       <= '0;
      range     <= aesm_pkg::mask_of(aesm_pkg::P_RESET);
      hv        <= 1'b0;
      hb        <= 1'b0;
      pend      <= '0;
      count     <= '0;
      spill_v   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      spill_v   <= spill_v_next;
      out_valid <= out_valid_next;
      if (cfg_write_en) begin
        prec  <= cfg_write_data;
        low   <= '0;
        range <= aesm_pkg::mask_of(aesm_pkg::clamp_p(cfg_write_data));
        hv    <= 1'b0;
        hb    <= 1'b0;
        pend  <= '0;
      end else begin
        low   <= low_next;
        range <= range_next;
        hv    <= hv_next;
        hb    <= hb_next;
        pend  <= pend_next;
      end
    end
  end

  assign code_bit   = out_run.bit_v;
  assign run_length = out_run.len;

endmodule

// File: rtl/arithmetic_encoder_static_model.sv
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    command, symbol, table_value
// out       output     out_valid / out_ready  code_bit, run_length, last, error
// cfg       input      cfg_write_en           cfg_write_data (precision)
//
// Steps: the back end writes a load as it is taken; an encode goes through take, two
//   table reads, two registered multiplies, check, renormalization bit by bit, its exit
//   and finish, a flush through take, add, renormalization, release and finish, plus a
//   step per extra run when two come out together; each result drains from the buffer.
// Reset: synchronous rst clears control state; precision returns to 16.
// Stalls: a two-entry request queue lets input be taken while results wait.

module arithmetic_encoder_static_model (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 command,
  input  logic [aesm_pkg::SYM_W-1:0] symbol,
  input  logic [aesm_pkg::VAL_W-1:0] table_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       code_bit,
  output logic [aesm_pkg::LEN_W-1:0] run_length,
  output logic                       last,
  output logic                       error,
  input  logic                       cfg_write_en,
  input  logic [aesm_pkg::P_W-1:0]   cfg_write_data
);

  logic           q_valid;
  logic           q_ready;
  aesm_pkg::req_t q_req;

  // front: accept and classify requests, drop the ones with no effect
  aesm_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .symbol      (symbol),
    .table_value (table_value),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_req       (q_req)
  );

  // back: table, interval arithmetic, renormalization and run output
  aesm_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .q_valid        (q_valid),
    .q_ready        (q_ready),
    .q_req          (q_req),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .code_bit       (code_bit),
    .run_length     (run_length),
    .last           (last),
    .error          (error)
  );

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps

// One expected or observed run of identical code bits
typedef struct {
  bit        bit_val;
  bit [16:0] run_len;
  bit        is_last;
  bit        is_err;
} code_run_t;

// Tracks the coder state and the code runs each accepted request must produce
class coder_scoreboard;
  bit [29:0]  cum_freq[255];
  bit [4:0]   precision;
  bit [63:0]  low;
  bit [63:0]  width;
  bit         held_valid;
  bit         held_bit;
  bit [63:0]  ones_pending;
  code_run_t  runs_due[$];
  code_run_t  runs_now[$];
  bit         req_err;
  int         mismatches;
  int         runs_checked;
  int         err_runs;

  function int p_used();
    int p;
    p = precision;
    if (p < aesm_pkg::P_MIN) p = aesm_pkg::P_MIN;
    if (p > aesm_pkg::P_MAX) p = aesm_pkg::P_MAX;
    return p;
  endfunction

  function void restart();
    low = 0;
    width = (64'd1 << p_used()) - 1;
    held_valid = 0;
    held_bit = 0;
    ones_pending = 0;
  endfunction

  function void set_precision(bit [4:0] v);
    precision = v;
    restart();
  endfunction

  function void push_run(bit b, bit [63:0] n);
    code_run_t r;
    if (n == 0 || runs_now.size() >= aesm_pkg::RES_DEPTH) return;
    r.bit_val = b;
    r.run_len = n[16:0];
    r.is_last = 0;
    r.is_err = 0;
    runs_now.push_back(r);
  endfunction

  function void release_held();
    if (!held_valid) return;
    if (held_bit) begin
      push_run(1, 1 + ones_pending);
    end else begin
      push_run(0, 1);
      push_run(1, ones_pending);
    end
    held_valid = 0;
    held_bit = 0;
    ones_pending = 0;
  endfunction

  function void emit(bit b);
    if (!held_valid) begin
      held_valid = 1;
      held_bit = b;
      ones_pending = 0;
    end else if (b) begin
      if (ones_pending >= 65535) req_err = 1;
      else ones_pending++;
    end else begin
      release_held();
      held_valid = 1;
      held_bit = 0;
      ones_pending = 0;
    end
  endfunction

  // 0 1..1 turns into 1 0..0; the last zero stays held
  function void carry();
    if (!held_valid || held_bit) return;
    if (ones_pending == 0) begin
      held_bit = 1;
      return;
    end
    push_run(1, 1);
    push_run(0, ones_pending - 1);
    held_bit = 0;
    ones_pending = 0;
  endfunction

  function bit [63:0] read_cum(int idx, bit [63:0] top);
    bit [63:0] v;
    if (idx == 0) return 0;
    if (idx >= 256) return top;
    v = cum_freq[idx-1];
    return (v > top) ? top : v;
  endfunction

  function void renorm(bit [63:0] nb, bit [63:0] nl, int p);
    bit [63:0] mask;
    bit [63:0] half;
    mask = (64'd1 << p) - 1;
    half = 64'd1 << (p - 1);
    while (nl != 0 && nl < half) begin
      emit(nb[p-1]);
      nl = (nl << 1) & mask;
      nb = (nb << 1) & mask;
    end
    low = nb;
    width = nl;
  endfunction

  function void note_request(aesm_pkg::cmd_t cmd, bit [7:0] sym, bit [29:0] val);
    int p;
    bit [63:0] one, mask, base, len, lo, hi, inc, y, sum, quarter;
    code_run_t r;
    p = p_used();
    one = 64'd1 << p;
    mask = one - 1;
    base = low & mask;
    len = width & mask;
    runs_now.delete();
    req_err = 0;
    r = '{0, 0, 0, 0};
    case (cmd)
      aesm_pkg::CMD_LOAD: begin
        if (sym >= 1) cum_freq[sym-1] = val;
        return;
      end
      aesm_pkg::CMD_NONE: return;
      aesm_pkg::CMD_ENCODE: begin
        lo = read_cum(sym, mask);
        hi = read_cum(int'(sym) + 1, mask);
        inc = (len * lo) >> p;
        y = (len * hi) >> p;
        if (y <= inc) begin
          req_err = 1;
        end else begin
          sum = base + inc;
          if (sum >= one) carry();
          renorm(sum & mask, y - inc, p);
        end
        if (req_err && runs_now.size() == 0) runs_now.push_back(r);
      end
      default: begin
        quarter = 64'd1 << (p - 2);
        sum = base + quarter;
        if (sum >= one) carry();
        renorm(sum & mask, quarter - 1, p);
        release_held();
        restart();
        if (req_err && runs_now.size() == 0) runs_now.push_back(r);
        if (runs_now.size() > 0) runs_now[runs_now.size()-1].is_last = 1;
      end
    endcase
    foreach (runs_now[k]) begin
      if (req_err) runs_now[k].is_err = 1;
      runs_due.push_back(runs_now[k]);
    end
  endfunction

  task report(string what);
    mismatches++;
    $display("[%0t] run %0d: %s", $realtime, runs_checked, what);
  endtask

  task check_run(bit b, bit [16:0] n, bit lst, bit err);
    code_run_t e;
    runs_checked++;
    if (err) err_runs++;
    if (runs_due.size() == 0) begin
      report($sformatf("unexpected run bit=%0d len=%0d", b, n));
      return;
    end
    e = runs_due.pop_front();
    if (b !== e.bit_val) report($sformatf("code_bit %0d, want %0d", b, e.bit_val));
    if (n !== e.run_len) report($sformatf("run_length %0d, want %0d", n, e.run_len));
    if (lst !== e.is_last) report($sformatf("last %0d, want %0d", lst, e.is_last));
    if (err !== e.is_err) report($sformatf("error %0d, want %0d", err, e.is_err));
  endtask
endclass

module tb_top;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE = 300;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_ready;
  logic [1:0]  command = aesm_pkg::CMD_NONE;
  logic [7:0]  symbol = 0;
  logic [29:0] table_value = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic        code_bit;
  logic [16:0] run_length;
  logic        last;
  logic        error;
  logic        cfg_write_en = 0;
  logic [4:0]  cfg_write_data = 0;

  coder_scoreboard sb = new;

  // steady flow: while set, sender and receiver add no random idles
  bit quiet = 0;
  int hold_asked = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycles = 0;
  int n_encode = 0;
  int n_flush = 0;
  int n_load = 0;

  arithmetic_encoder_static_model dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .symbol(symbol), .table_value(table_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .code_bit(code_bit), .run_length(run_length), .last(last), .error(error),
    .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("arithmetic_encoder_static_model: mismatch");
      $finish;
    end
  end

  // Receiver: check each accepted run, then pick ready for the next edge.
  // A long hold-off is counted here once the main flow asks for one.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_run(code_bit, run_length, last, error);
    if (hold_seen != hold_asked) begin
      hold_seen = hold_asked;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 0;
    end else begin
      out_ready <= quiet || ($urandom_range(0, 99) >= 15);
    end
  end

  // Symbols whose table entries are loaded: the low block and the top block
  function automatic bit [7:0] pick_sym();
    int r;
    r = $urandom_range(0, 27);
    return (r < 24) ? 8'(r) : 8'(r + 228);
  endfunction

  // Offer one request and hold it until the block takes it. The valid line is
  // left high after acceptance so back-to-back requests need no gap.
  task send_request(aesm_pkg::cmd_t cmd, bit [7:0] sym, bit [29:0] val);
    while (!quiet && $urandom_range(0, 99) < 15) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    command <= cmd;
    symbol <= sym;
    table_value <= val;
    do @(posedge clk); while (!in_ready);
    sb.note_request(cmd, sym, val);
    case (cmd)
      aesm_pkg::CMD_ENCODE: n_encode++;
      aesm_pkg::CMD_FLUSH:  n_flush++;
      aesm_pkg::CMD_LOAD:   n_load++;
      default: ;
    endcase
  endtask

  // Drop valid, wait for every expected run, then let any held work settle
  task drain();
    in_valid <= 0;
    while (sb.runs_due.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task write_precision(bit [4:0] v);
    drain();
    cfg_write_en <= 1;
    cfg_write_data <= v;
    @(posedge clk);
    sb.set_precision(v);
    cfg_write_en <= 0;
  endtask

  // Mostly encodes with random symbols, some flushes, table rewrites and noise
  task random_requests(int count);
    int pick;
    bit [7:0] idx;
    bit [29:0] v;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      idx = pick_sym();
      if (idx == 8'd0) idx = 8'd1;
      v = ($urandom_range(0, 3) == 0) ? 30'($urandom) : 30'($urandom_range(0, 510));
      if (pick < 70) send_request(aesm_pkg::CMD_ENCODE, pick_sym(), 30'($urandom));
      else if (pick < 80)
        send_request(aesm_pkg::CMD_FLUSH, 8'($urandom_range(0, 255)), 30'($urandom));
      else if (pick < 92) send_request(aesm_pkg::CMD_LOAD, idx, v);
      else if (pick < 95) send_request(aesm_pkg::CMD_LOAD, 8'd0, 30'($urandom));
      else send_request(aesm_pkg::CMD_NONE, 8'($urandom_range(0, 255)), 30'($urandom));
    end
  endtask

  initial begin
    sb.set_precision(aesm_pkg::P_RESET);
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Fill the two table blocks that encodes use so no unwritten entry is ever
    // read; a step of two keeps every entry below the narrowest interval.
    quiet = 1;
    for (int i = 1; i < 25; i++)
      send_request(aesm_pkg::CMD_LOAD, i[7:0], 30'(2 * i));
    for (int i = 252; i < 256; i++)
      send_request(aesm_pkg::CMD_LOAD, i[7:0], 30'(2 * i));
    quiet = 0;

    // Directed: edge symbols, saturated and non-increasing entries, ignored
    // requests, flush with and without held bits
    send_request(aesm_pkg::CMD_ENCODE, 8'd0, '0);
    send_request(aesm_pkg::CMD_ENCODE, 8'd255, '1);
    send_request(aesm_pkg::CMD_ENCODE, 8'd1, '0);
    send_request(aesm_pkg::CMD_ENCODE, 8'd20, '0);
    send_request(aesm_pkg::CMD_LOAD, 8'd5, 30'h3FFFFFFF);
    send_request(aesm_pkg::CMD_ENCODE, 8'd5, '0);
    send_request(aesm_pkg::CMD_ENCODE, 8'd4, '0);
    send_request(aesm_pkg::CMD_LOAD, 8'd5, 30'd10);
    send_request(aesm_pkg::CMD_LOAD, 8'd0, 30'h2AAAAAAA);
    send_request(aesm_pkg::CMD_NONE, 8'd255, 30'h15555555);
    send_request(aesm_pkg::CMD_LOAD, 8'd6, 30'd10);
    send_request(aesm_pkg::CMD_ENCODE, 8'd5, '0);
    send_request(aesm_pkg::CMD_LOAD, 8'd6, 30'd12);
    send_request(aesm_pkg::CMD_ENCODE, 8'd5, '0);
    send_request(aesm_pkg::CMD_FLUSH, 8'd0, '0);
    send_request(aesm_pkg::CMD_FLUSH, 8'd0, '0);
    send_request(aesm_pkg::CMD_ENCODE, 8'd255, '0);
    send_request(aesm_pkg::CMD_ENCODE, 8'd255, '0);
    send_request(aesm_pkg::CMD_ENCODE, 8'd254, '0);
    send_request(aesm_pkg::CMD_FLUSH, 8'd255, '0);

    // Settings sweep: below the clamp, both ends, all ones, a random middle value, reset value
    write_precision(5'd0);
    quiet = 1;
    random_requests(15);
    quiet = 0;
    write_precision(5'd30);
    random_requests(15);

    // Stall the receiver while requests keep coming so the block backs up
    hold_asked++;
    quiet = 1;
    repeat (20) send_request(aesm_pkg::CMD_ENCODE, pick_sym(), '0);
    quiet = 0;
    send_request(aesm_pkg::CMD_FLUSH, 8'd0, '0);

    write_precision(5'd9);
    random_requests(15);
    write_precision(5'd31);
    random_requests(15);
    write_precision(5'($urandom_range(10, 29)));
    random_requests(15);
    write_precision(aesm_pkg::P_RESET);
    random_requests(15);
    send_request(aesm_pkg::CMD_FLUSH, 8'd0, '0);
    drain();

    $display("covered %0d encodes, %0d flushes, %0d table loads over six precisions",
             n_encode, n_flush, n_load);
    $display("checked %0d code runs, %0d flagged as errors", sb.runs_checked, sb.err_runs);
    if (sb.mismatches == 0 && sb.runs_due.size() == 0) begin
      $display("arithmetic_encoder_static_model: match");
    end else begin
      $display("arithmetic_encoder_static_model: mismatch");
    end
    $finish;
  end
endmodule
